### src/assert_macros.svh
// Shared concurrent assertion forms for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_CLK(label, clk, rstn, !(cond), msg)

`endif

### src/sfr_pkg.sv
package sfr_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_REPL_DEF    = 16;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN,
    CFG_PAT_LOW,
    CFG_PAT_HIGH,
    CFG_REP_LEN,
    CFG_REP_LOW,
    CFG_REP_HIGH,
    CFG_FOLD_CASE
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
  } sfr_out_t;

  // Per-cycle control broadcast to every window cell.
  typedef struct packed {
    logic adv;
    logic shift;
    logic fold_en;
  } cell_ctl_t;

  // Attributes of a job handed to the output buffer.
  typedef struct packed {
    logic eos;
    logic marker;
  } job_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    if (en && b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

endpackage

### src/stream_find_replace.sv
// Byte-stream find and replace. Bytes enter on in_* and pass through a row of
// window cells, each holding one byte and comparing it with its pattern byte;
// a full window that equals the pattern is replaced, otherwise its oldest
// byte leaves. Rewritten bytes queue in a job buffer ahead of a registered
// out_* stage. The pattern length is latched when a byte arrives at an empty
// window. An item with at most one result is taken every cycle while out_stall
// is low; one with N results (N replacement bytes, or N window bytes flushed at
// end of string) holds in_stall until the single output register, one byte per
// cycle while out_stall is low, is down to the last of them. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while the stream is idle.
`include "assert_macros.svh"

module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPL_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sfr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sfr_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int JD = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(JD + 1);

  logic [LEN_W-1:0]        pat_len_r;
  logic [2*CFG_DATA_W-1:0] pat_r;
  logic [LEN_W-1:0]        rep_len_r;
  logic [2*CFG_DATA_W-1:0] rep_r;
  logic                    fold_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] active_r;
  logic [CW-1:0] act;
  logic [CW-1:0] cnt1;
  logic [CW-1:0] eff_plen;
  logic [RW-1:0] eff_rlen;

  logic                        accept;
  logic                        eos;
  logic                        full;
  logic                        match;
  logic [MAX_PATTERN-1:0]      hit;
  logic [MAX_PATTERN-1:0][7:0] win;
  cell_ctl_t                   cell_ctl;

  logic [JD-1:0][7:0] job_bytes;
  logic [RW-1:0]      job_cnt;
  job_ctl_t           job_ctl;
  logic [RW-1:0]      job_rem;

  logic active_bad;
  logic eos_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= LEN_W'(1);
      pat_r     <= '0;
      rep_len_r <= '0;
      rep_r     <= '0;
      fold_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LEN:   pat_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_PAT_LOW:   pat_r[CFG_DATA_W-1:0] <= cfg_wdata;
        CFG_PAT_HIGH:  pat_r[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata;
        CFG_REP_LEN:   rep_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_REP_LOW:   rep_r[CFG_DATA_W-1:0] <= cfg_wdata;
        CFG_REP_HIGH:  rep_r[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata;
        CFG_FOLD_CASE: fold_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pat_len_r == '0) begin
      eff_plen = CW'(1);
    end else if (pat_len_r > LEN_W'(MAX_PATTERN)) begin
      eff_plen = CW'(MAX_PATTERN);
    end else begin
      eff_plen = CW'(pat_len_r);
    end
    if (rep_len_r > LEN_W'(MAX_REPLACEMENT)) begin
      eff_rlen = RW'(MAX_REPLACEMENT);
    end else begin
      eff_rlen = RW'(rep_len_r);
    end
  end

  assign accept = in_valid && !in_stall;
  assign eos    = in_data.end_of_string;
  assign act    = (count_r == '0) ? eff_plen : active_r;
  assign cnt1   = count_r + CW'(1);
  assign full   = (cnt1 >= act);
  assign match  = full && (&hit);

  assign cell_ctl.adv     = accept;
  assign cell_ctl.shift   = full && !match;
  assign cell_ctl.fold_en = fold_r;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] right;
    if (i == MAX_PATTERN - 1) begin : g_end
      assign right = 8'h00;
    end else begin : g_mid
      assign right = win[i+1];
    end
    sfr_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .wr_pos     (count_r),
      .act_len    (act),
      .new_byte   (in_data.in_byte),
      .from_right (right),
      .pat_byte   (pat_r[8*i +: 8]),
      .cur_byte   (win[i]),
      .hit        (hit[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (eos || match) begin
      count_nxt = '0;
    end else if (full) begin
      count_nxt = count_r;
    end else begin
      count_nxt = cnt1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= CW'(1);
    end else if (accept) begin
      count_r  <= count_nxt;
      active_r <= act;
    end
  end

  // Job for the output buffer: the replacement, or the window oldest first.
  // An empty end marker carries a zero byte.
  for (genvar i = 0; i < JD; i++) begin : g_job
    logic [7:0] rep_b;
    logic [7:0] win_b;
    if (i < MAX_REPLACEMENT) begin : g_rep
      assign rep_b = rep_r[8*i +: 8];
    end else begin : g_norep
      assign rep_b = 8'h00;
    end
    if (i < MAX_PATTERN) begin : g_win
      assign win_b = win[i];
    end else begin : g_nowin
      assign win_b = 8'h00;
    end
    assign job_bytes[i] = job_ctl.marker ? 8'h00 : (match ? rep_b : win_b);
  end

  always_comb begin
    job_ctl.eos    = eos;
    job_ctl.marker = match && eos && (eff_rlen == '0);
    if (match) begin
      job_cnt = job_ctl.marker ? RW'(1) : eff_rlen;
    end else if (eos) begin
      job_cnt = RW'(cnt1);
    end else begin
      job_cnt = full ? RW'(1) : '0;
    end
  end

  sfr_emit #(
    .DEPTH (JD)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_bytes (job_bytes),
    .load_cnt   (job_cnt),
    .load_ctl   (job_ctl),
    .busy       (in_stall),
    .rem        (job_rem),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign active_bad = (active_r == '0) || (active_r > CW'(MAX_PATTERN));
  assign eos_take   = accept && eos;

  `ASSERT_CLK(a_count_below_len, clk, rst_n, (count_r < active_r), "count past length")
  `ASSERT_NEVER(a_active_range, clk, rst_n, active_bad, "latched length out of range")
  `ASSERT_CLK(a_eos_clears, clk, rst_n, eos_take |=> (count_r == '0), "window not empty")
  `ASSERT_CLK(a_eos_has_result, clk, rst_n, eos_take |=> (job_rem != '0), "no end result")

endmodule

### src/sfr_cell.sv
module sfr_cell import sfr_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] wr_pos,
  input  logic [CW-1:0] act_len,
  input  logic [7:0]    new_byte,
  input  logic [7:0]    from_right,
  input  logic [7:0]    pat_byte,
  output logic [7:0]    cur_byte,
  output logic          hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // The arriving byte lands in the cell at the current fill position.
  assign cur_byte = (wr_pos == CW'(IDX)) ? new_byte : byte_r;

  assign hit = (CW'(IDX) >= act_len) ||
               (fold_byte(cur_byte, ctl.fold_en) == fold_byte(pat_byte, ctl.fold_en));

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.adv) begin
      byte_nxt = ctl.shift ? from_right : cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

### src/sfr_emit.sv
module sfr_emit import sfr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [DEPTH-1:0][7:0]          load_bytes,
  input  logic [$clog2(DEPTH+1)-1:0]     load_cnt,
  input  job_ctl_t                       load_ctl,
  output logic                           busy,
  output logic [$clog2(DEPTH+1)-1:0]     rem,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sfr_out_t                       out_data
);

  localparam int RW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][7:0] buf_r;
  logic [RW-1:0]         rem_r;
  job_ctl_t              ctl_r;
  logic                  out_valid_r;
  sfr_out_t              out_data_r;
  logic                  pop;
  logic                  last;

  assign last = (rem_r == RW'(1));
  assign pop  = (rem_r != '0) && (!out_valid_r || !out_stall);
  // Take a new job once the buffer is empty or down to a byte that leaves this cycle.
  assign busy = (rem_r > RW'(1)) || (last && !pop);

  assign rem       = rem_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        rem_r <= load_cnt;
      end else if (pop) begin
        rem_r <= rem_r - RW'(1);
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_bytes;
      ctl_r <= load_ctl;
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
    if (pop) begin
      out_data_r.out_byte    <= buf_r[0];
      out_data_r.byte_valid  <= !ctl_r.marker;
      out_data_r.run_last    <= last;
      out_data_r.string_done <= last && ctl_r.eos;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  localparam int SETTLE = 40;
  localparam int WIN_MAX = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sfr_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sfr_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  stream_find_replace dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Mirror of the block's registers and window
  logic [4:0] pat_len_r = 5'd1;
  logic [127:0] pat_bits = '0;
  logic [4:0] rep_len_r = 5'd0;
  logic [127:0] rep_bits = '0;
  logic fold_r = 1'b0;
  logic [7:0] win [WIN_MAX];
  int win_cnt = 0;
  int act_len = 1;

  sfr_in_t byte_q[$];
  sfr_out_t rewritten_q[$];

  int n_queued = 0;
  int n_taken = 0;
  int n_strings = 0;
  int n_hits = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  bit no_idle = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] b);
    if (fold_r && b >= 8'h61 && b <= 8'h7A) return {b[7:6], 1'b0, b[4:0]};
    return b;
  endfunction

  // Work out the rewritten bytes that one transfer produces
  task automatic rewrite_step(input sfr_in_t it);
    sfr_out_t res[$];
    sfr_out_t o;
    logic hit;
    int rl;
    if (win_cnt == 0) begin
      if (pat_len_r == 0) act_len = 1;
      else if (pat_len_r > WIN_MAX) act_len = WIN_MAX;
      else act_len = pat_len_r;
    end
    if (win_cnt < WIN_MAX) begin
      win[win_cnt] = it.in_byte;
      win_cnt++;
    end
    if (win_cnt >= act_len) begin
      hit = 1'b1;
      for (int i = 0; i < act_len; i++)
        if (upcase(win[i]) != upcase(pat_bits[8*i +: 8])) hit = 1'b0;
      if (hit) begin
        rl = (rep_len_r > WIN_MAX) ? WIN_MAX : rep_len_r;
        for (int i = 0; i < rl; i++) begin
          o = '{out_byte: rep_bits[8*i +: 8], byte_valid: 1'b1, run_last: 1'b0,
                string_done: 1'b0};
          res.push_back(o);
        end
        win_cnt = 0;
        n_hits++;
      end else begin
        o = '{out_byte: win[0], byte_valid: 1'b1, run_last: 1'b0, string_done: 1'b0};
        res.push_back(o);
        for (int i = 0; i < WIN_MAX - 1; i++) win[i] = win[i+1];
        win_cnt--;
      end
    end
    if (it.end_of_string) begin
      for (int i = 0; i < win_cnt; i++) begin
        o = '{out_byte: win[i], byte_valid: 1'b1, run_last: 1'b0, string_done: 1'b0};
        res.push_back(o);
      end
      win_cnt = 0;
      if (res.size() == 0) begin
        o = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0, string_done: 1'b0};
        res.push_back(o);
      end
      n_strings++;
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last = 1'b1;
      res[res.size()-1].string_done = it.end_of_string;
    end
    foreach (res[i]) rewritten_q.push_back(res[i]);
  endtask

  // Driver: hold the payload while stalled, advance after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rewrite_step(in_data);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
          gap_left = no_idle ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Fields print as byte/valid/last/done
  task automatic note_mismatch(input string what, input sfr_out_t e, input sfr_out_t a);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t: %s exp %02h/%b/%b/%b got %02h/%b/%b/%b",
               $realtime, what, e.out_byte, e.byte_valid, e.run_last, e.string_done,
               a.out_byte, a.byte_valid, a.run_last, a.string_done);
  endtask

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    sfr_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (rewritten_q.size() == 0) begin
          note_mismatch("unexpected result:", '0, out_data);
        end else begin
          e = rewritten_q.pop_front();
          if (out_data.out_byte !== e.out_byte || out_data.byte_valid !== e.byte_valid ||
              out_data.run_last !== e.run_last || out_data.string_done !== e.string_done)
            note_mismatch("mismatch:", e, out_data);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_PAT_LEN:   pat_len_r = v[4:0];
      CFG_PAT_LOW:   pat_bits[63:0] = v;
      CFG_PAT_HIGH:  pat_bits[127:64] = v;
      CFG_REP_LEN:   rep_len_r = v[4:0];
      CFG_REP_LOW:   rep_bits[63:0] = v;
      CFG_REP_HIGH:  rep_bits[127:64] = v;
      CFG_FOLD_CASE: fold_r = v[0];
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input int plen, input logic [127:0] pv, input int rlen,
                              input logic [127:0] rv, input bit fold);
    set_reg(CFG_PAT_LEN, plen);
    set_reg(CFG_PAT_LOW, pv[63:0]);
    set_reg(CFG_PAT_HIGH, pv[127:64]);
    set_reg(CFG_REP_LEN, rlen);
    set_reg(CFG_REP_LOW, rv[63:0]);
    set_reg(CFG_REP_HIGH, rv[127:64]);
    set_reg(CFG_FOLD_CASE, fold);
    close_cfg();
    n_settings++;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit eos);
    sfr_in_t it;
    it.in_byte = b;
    it.end_of_string = eos;
    byte_q.push_back(it);
    n_queued++;
  endtask

  // Wait for every transfer and result, then let the block settle
  task automatic drain();
    while (n_taken != n_queued || rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [127:0] pv;
    logic [127:0] rv;
    logic [7:0] alphabet [6];
    logic [7:0] b;
    int plen, rlen, cnt, nch, r, k;
    bit fold;
    alphabet = '{8'h41, 8'h61, 8'h42, 8'h62, 8'h5B, 8'h7B};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: single 0x00 pattern, deleted on match
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b1);
    drain();

    // Oversized replacement length saturates; folded compare around the letter edges
    pv = rand128();
    pv[15:0] = {8'h42, 8'h61};
    load_setting(2, pv, 31, rand128(), 1'b1);
    push_byte(8'h41, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h60, 1'b0);
    push_byte(8'h7B, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h5B, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b1);
    drain();

    // Full-width pattern, then shorten it while the window is partly filled
    for (int i = 0; i < 16; i++) pv[8*i +: 8] = 8'h80 + 8'(i * 7);
    load_setting(31, pv, 1, rand128(), 1'b0);
    for (int i = 0; i < 15; i++) push_byte(pv[8*i +: 8], 1'b0);
    drain();
    set_reg(CFG_PAT_LEN, 0);
    close_cfg();
    push_byte(pv[127:120], 1'b1);
    push_byte(pv[7:0], 1'b1);
    drain();

    // Random settings, strings built mostly from pattern copies
    for (int ph = 0; ph < 6; ph++) begin
      plen = (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(2, 6);
      rlen = (ph == 0) ? 16 : (ph == 1) ? 0 : $urandom_range(0, 16);
      fold = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      pv = rand128();
      for (int i = 0; i < plen; i++) pv[8*i +: 8] = alphabet[$urandom_range(0, 5)];
      load_setting(plen, pv, rlen, rand128(), fold);
      no_idle = (ph == 2);
      cnt = 0;
      while (cnt < 15) begin
        nch = $urandom_range(1, 5);
        for (int c = 0; c < nch; c++) begin
          r = $urandom_range(0, 99);
          if (r < 55) k = plen;
          else if (r < 75) k = $urandom_range(1, plen);
          else k = $urandom_range(1, 3);
          for (int j = 0; j < k; j++) begin
            if (r < 75) begin
              b = pv[8*j +: 8];
              if ((b[7:5] == 3'b010 || b[7:5] == 3'b011) && b[4:0] >= 5'd1 &&
                  b[4:0] <= 5'd26 && $urandom_range(0, 3) == 0)
                b = b ^ 8'h20;
            end else begin
              b = 8'($urandom_range(0, 255));
            end
            push_byte(b, c == nch - 1 && j == k - 1);
            cnt++;
          end
        end
      end
      drain();
    end
    no_idle = 1'b0;

    $display("Ran %0d strings, %0d input bytes, over %0d register settings.",
             n_strings, n_taken, n_settings);
    $display("Saw %0d pattern hits and checked %0d output bytes; %0d left unmatched.",
             n_hits, n_results, rewritten_q.size());
    if (n_errors == 0 && rewritten_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d of %0d bytes taken.", n_taken, n_queued);
    $display("TB_ERROR");
    $finish;
  end

endmodule

### stream_find_replace.f
+incdir+src
src/sfr_pkg.sv
src/sfr_cell.sv
src/sfr_emit.sv
src/stream_find_replace.sv
dv/tb.sv
